FILE: hw/rtl/trimmed_mean_adc_averager_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trimmed mean averager
// Shared helpers for concurrent checks clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_ADC_AVERAGER_DEFINES_SVH
`define TRIMMED_MEAN_ADC_AVERAGER_DEFINES_SVH

// Same-cycle implication.
`define TMA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg
// Widths, constants, state encoding and interface structs of the averager.
// ----------------------------------------------------------------------------
`default_nettype none

package tma_pkg;

	localparam int SMP_W      = 24;
	localparam int SUM_W      = 28;
	localparam int CNT_W      = 4;
	localparam int MV_W       = 29;
	localparam int MV_SCALE_W = 13;
	localparam int PROD_W     = SMP_W - 1 + MV_SCALE_W;
	localparam int MV_SHIFT   = 7;
	localparam int DIV_STEP_W = $clog2(SUM_W);

	localparam logic [MV_SCALE_W-1:0] MV_SCALE  = 13'd5000;
	localparam logic [CNT_W-1:0]      CNT_RESET = 4'd10;
	localparam logic [CNT_W-1:0]      CNT_MIN   = 4'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_SCALE,
		ST_LOAD
	} tma_state_t;

	typedef struct packed {
		logic             load;
		logic             clear;
		logic [SMP_W-1:0] smp;
	} tma_acc_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SMP_W-1:0] low;
		logic [SMP_W-1:0] high;
		logic [CNT_W-1:0] taken;
	} tma_acc_st_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} tma_div_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tma_accum.sv
// ----------------------------------------------------------------------------
// tma_accum
// Running sum, lowest and highest sample, and sample count of one set.
// ----------------------------------------------------------------------------
`default_nettype none

module tma_accum
	import tma_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire tma_acc_ctl_t ctl,
	output tma_acc_st_t   st
);

	logic [SUM_W-1:0] sum_q;
	logic [SMP_W-1:0] low_q;
	logic [SMP_W-1:0] high_q;
	logic [CNT_W-1:0] taken_q;
	logic             first;

	assign first = (taken_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			taken_q <= '0;
		end else if (ctl.clear) begin
			sum_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			taken_q <= '0;
		end else if (ctl.load) begin
			// The first sample of a set seeds both extremes.
			if (first || ctl.smp < low_q) begin
				low_q <= ctl.smp;
			end
			if (first || ctl.smp > high_q) begin
				high_q <= ctl.smp;
			end
			sum_q   <= sum_q + SUM_W'(ctl.smp);
			taken_q <= taken_q + CNT_W'(1);
		end
	end

	assign st.sum   = sum_q;
	assign st.low   = low_q;
	assign st.high  = high_q;
	assign st.taken = taken_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tma_div.sv
// ----------------------------------------------------------------------------
// tma_div
// Restoring divider: one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module tma_div
	import tma_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire tma_div_req_t req,
	output logic              done,
	output logic [SMP_W-1:0]  quotient
);

	logic [SUM_W-1:0]      quo_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      dvs_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [CNT_W:0]        rem_sh;
	logic [CNT_W:0]        diff;
	logic                  ge;
	logic                  last_step;

	assign rem_sh    = {rem_q, quo_q[SUM_W-1]};
	assign ge        = (rem_sh >= {1'b0, dvs_q});
	assign diff      = rem_sh - {1'b0, dvs_q};
	assign last_step = (cnt_q == DIV_STEP_W'(SUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_STEP_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The remainder stays below the divisor, so four bits hold it.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[SMP_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/trimmed_mean_adc_averager.sv
// ----------------------------------------------------------------------------
// trimmed_mean_adc_averager
// Averages a set of converter samples with the lowest and highest dropped,
// and scales the result to millivolts in unsigned Q.16.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  input    | in_valid / in_stall        | sample, read_failed
//  output   | out_valid / out_stall      | average, millivolts_q16, failed
//  config   | cfg_wr_en                  | cfg_wr_data (sample_count)
//
//  A sample that does not close its set goes ST_EVAL then ST_IDLE; a failed read
//  goes ST_LOAD. A closing sample runs ST_EVAL, ST_DIV (one-bit-per-cycle divider),
//  ST_SCALE and ST_LOAD, and skips ST_DIV when all samples of the set match.
//  The input stalls while a beat is in work; a result waiting in the output
//  register does not stall the next input until another result is ready.
//  Reset clears the set and sets sample_count to 10.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trimmed_mean_adc_averager_defines.svh"

module trimmed_mean_adc_averager
	import tma_pkg::*;
#(
	parameter int MAX_SAMPLES = 11
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire  [CNT_W-1:0]       cfg_wr_data,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [SMP_W-1:0]       sample,
	input  wire                    read_failed,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [SMP_W-1:0]       average,
	output logic [MV_W-1:0]        millivolts_q16,
	output logic                   failed
);

	// The sample counter is four bits wide, so a larger limit never bites.
	localparam int                CNT_HI_INT = (MAX_SAMPLES > 15) ? 15 : MAX_SAMPLES;
	localparam logic [CNT_W-1:0] CNT_HI     = CNT_W'(CNT_HI_INT);

	tma_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cfg_q;
	logic [CNT_W-1:0]  eff_n;

	tma_acc_ctl_t      acc_ctl;
	tma_acc_st_t       acc_st;
	tma_div_req_t      div_req;
	logic              div_done;
	logic [SMP_W-1:0]  div_quo;

	logic              in_acc;
	logic              set_done;
	logic              same;
	logic              out_free;
	logic              out_load;

	logic [SMP_W-1:0]  avg_q;
	logic [MV_W-1:0]   mv_q;
	logic              fail_q;
	logic [PROD_W-1:0] prod_a, prod_b, prod;

	logic              out_valid_q;
	logic [SMP_W-1:0]  average_q;
	logic [MV_W-1:0]   mv_out_q;
	logic              failed_q;

	always_comb begin
		eff_n = cfg_q;
		if (cfg_q < CNT_MIN) begin
			eff_n = CNT_MIN;
		end else if (cfg_q > CNT_HI) begin
			eff_n = CNT_HI;
		end
	end

	assign in_acc   = in_valid && !in_stall;
	assign set_done = (acc_st.taken >= eff_n);
	assign same     = (acc_st.low == acc_st.high);
	assign out_free = !out_valid_q || !out_stall;

	tma_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.st     (acc_st)
	);

	tma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		out_load         = 1'b0;
		acc_ctl.load     = 1'b0;
		acc_ctl.clear    = 1'b0;
		acc_ctl.smp      = sample;
		div_req.start    = 1'b0;
		div_req.dividend = acc_st.sum - SUM_W'(acc_st.low) - SUM_W'(acc_st.high);
		div_req.divisor  = acc_st.taken - CNT_W'(2);
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (read_failed) begin
						acc_ctl.clear = 1'b1;
						state_d       = ST_LOAD;
					end else begin
						acc_ctl.load = 1'b1;
						state_d      = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				if (!set_done) begin
					state_d = ST_IDLE;
				end else begin
					acc_ctl.clear = 1'b1;
					if (same) begin
						state_d = ST_SCALE;
					end else begin
						div_req.start = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Offset from half scale times 5000; only the 23 low bits matter when bit 23 is set.
	assign prod_a = {{(PROD_W - SMP_W + 1){1'b0}}, avg_q[SMP_W-2:0]};
	assign prod_b = {{(PROD_W - MV_SCALE_W){1'b0}}, MV_SCALE};
	assign prod   = prod_a * prod_b;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fail_q <= read_failed;
			avg_q  <= '0;
			mv_q   <= '0;
		end
		if (state_q == ST_EVAL && set_done && same) begin
			avg_q <= acc_st.low;
		end
		if (state_q == ST_DIV && div_done) begin
			avg_q <= div_quo;
		end
		if (state_q == ST_SCALE) begin
			mv_q <= avg_q[SMP_W-1] ? prod[MV_SHIFT +: MV_W] : '0;
		end
		if (out_load) begin
			average_q <= avg_q;
			mv_out_q  <= mv_q;
			failed_q  <= fail_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign average        = average_q;
	assign millivolts_q16 = mv_out_q;
	assign failed         = failed_q;

	`TMA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "input taken while busy")
	`TMA_ASSERT_NOW(a_fail_zero, out_valid && failed, average == '0 && millivolts_q16 == '0, "failed beat carries data")
	`TMA_ASSERT_NOW(a_low_half_zero, out_valid && !average[SMP_W-1], millivolts_q16 == '0, "voltage set below half scale")
	`TMA_ASSERT_NOW(a_div_done_state, div_done, state_q == ST_DIV, "divider finished outside divide state")

endmodule

`default_nettype wire
